// ===== rtl/mpfb_pkg.sv =====
// Shared types and codes for the page-mode framebuffer blit block.
package mpfb_pkg;

	// Request codes carried in req_type
	localparam logic [1:0] REQ_BLIT     = 2'd0;
	localparam logic [1:0] REQ_PAGE_RD  = 2'd1;
	localparam logic [1:0] REQ_PIXEL_RD = 2'd2;

	// Transparency modes carried in blit_mode
	localparam logic [1:0] MODE_OPAQUE    = 2'd0;
	localparam logic [1:0] MODE_BLACK_CLR = 2'd1;
	localparam logic [1:0] MODE_WHITE_CLR = 2'd2;
	localparam logic [1:0] MODE_MID_CLR   = 2'd3;

	localparam logic [7:0] PIX_ON  = 8'hFF;
	localparam logic [7:0] PIX_OFF = 8'h00;

	// Input word
	typedef struct packed {
		logic [1:0] req_type;
		logic [6:0] pos_x;
		logic [5:0] pos_y;
		logic [2:0] page_index;
		logic [7:0] src_value;
		logic [1:0] blit_mode;
	} in_word_t;

	// Result word
	typedef struct packed {
		logic [7:0] read_data;
		logic       pixel_changed;
	} out_word_t;

	// Operation decided by the front end
	typedef enum logic [2:0] {
		OP_NONE,
		OP_SET,
		OP_CLR,
		OP_RD_PAGE,
		OP_RD_PIX
	} op_t;

	// Classified command minus its address
	typedef struct packed {
		op_t        op;
		logic [2:0] bit_sel;
	} cmd_t;

endpackage

// ===== rtl/mpfb_front.sv =====
// Front end: accepts request words, range-checks them and turns them into commands.
module mpfb_front #(
	parameter int DISPLAY_WIDTH = 128,
	parameter int MAX_ROWS      = 64,
	parameter int AW            = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  mpfb_pkg::in_word_t in_word,
	input  logic               store_ready,
	input  logic               q_ready,
	output logic               q_push,
	output mpfb_pkg::cmd_t     q_cmd,
	output logic [AW-1:0]      q_addr
);
	import mpfb_pkg::*;

	localparam logic [8:0] WIDTH_LIM = 9'(DISPLAY_WIDTH);
	localparam logic [7:0] FULL_ROWS = 8'(MAX_ROWS);
	localparam logic [7:0] HALF_ROWS = 8'(MAX_ROWS / 2);
	localparam logic [4:0] FULL_PAGES = 5'(MAX_ROWS / 8);
	localparam logic [4:0] HALF_PAGES = 5'(MAX_ROWS / 2 / 8);

	logic       short_panel_q;
	logic [7:0] rows_lim;
	logic [4:0] pages_lim;
	logic       x_ok;
	logic       pix_ok;
	logic       page_ok;
	logic [2:0] page_sel;

	// Panel height register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_panel_q <= 1'b0;
		end else if (cfg_we) begin
			short_panel_q <= cfg_wdata;
		end
	end

	// Range checks against the configured height
	always_comb begin
		rows_lim  = short_panel_q ? HALF_ROWS : FULL_ROWS;
		pages_lim = short_panel_q ? HALF_PAGES : FULL_PAGES;
		x_ok      = {2'b00, in_word.pos_x} < WIDTH_LIM;
		pix_ok    = x_ok && ({2'b00, in_word.pos_y} < rows_lim)
			&& ({2'b00, in_word.pos_y[5:3]} < FULL_PAGES);
		page_ok   = x_ok && ({2'b00, in_word.page_index} < pages_lim);
	end

	// Classify the request
	always_comb begin
		q_cmd.op      = OP_NONE;
		q_cmd.bit_sel = in_word.pos_y[2:0];
		page_sel      = in_word.pos_y[5:3];
		unique case (in_word.req_type)
			REQ_BLIT: begin
				if (pix_ok) begin
					unique case (in_word.blit_mode)
						MODE_OPAQUE: begin
							q_cmd.op = (in_word.src_value != PIX_OFF) ? OP_SET : OP_CLR;
						end
						MODE_BLACK_CLR: begin
							if (in_word.src_value != PIX_OFF) q_cmd.op = OP_SET;
						end
						MODE_WHITE_CLR: begin
							if (in_word.src_value == PIX_OFF) q_cmd.op = OP_CLR;
						end
						MODE_MID_CLR: begin
							if (in_word.src_value == PIX_OFF) q_cmd.op = OP_CLR;
							else if (in_word.src_value == PIX_ON) q_cmd.op = OP_SET;
						end
						default: q_cmd.op = OP_NONE;
					endcase
				end
			end
			REQ_PAGE_RD: begin
				page_sel = in_word.page_index;
				if (page_ok) q_cmd.op = OP_RD_PAGE;
			end
			REQ_PIXEL_RD: begin
				if (pix_ok) q_cmd.op = OP_RD_PIX;
			end
			default: q_cmd.op = OP_NONE;
		endcase
		q_addr = AW'(page_sel) * AW'(DISPLAY_WIDTH) + AW'(in_word.pos_x);
	end

	// Handshake into the queue
	assign in_ready = q_ready && store_ready;
	assign q_push   = in_valid && in_ready;

endmodule

// ===== rtl/mpfb_queue.sv =====
// Small command queue between the front end and the store back end.
module mpfb_queue #(
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	output logic          push_ready,
	input  logic          pop,
	output logic          pop_valid,
	output logic [DW-1:0] pop_data
);
	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	logic [DW-1:0] slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign push_ready = count_q != (PW+1)'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = slot_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/mpfb_back.sv =====
// Back end: page store memory, read-modify-write stage and result register.
module mpfb_back #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  mpfb_pkg::cmd_t      q_cmd,
	input  logic [AW-1:0]       q_addr,
	output logic                q_pop,
	output logic                store_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output mpfb_pkg::out_word_t out_word
);
	import mpfb_pkg::*;

	logic [7:0]    store_mem [DEPTH];

	logic          clr_busy_q;
	logic [AW-1:0] clr_idx_q;

	logic          s1_valid_q;
	cmd_t          s1_cmd_q;
	logic [AW-1:0] s1_addr_q;
	logic [7:0]    mem_rd_q;
	logic [7:0]    fwd_q;
	logic          fwd_sel_q;

	logic          out_valid_q;
	out_word_t     out_word_q;

	logic [7:0]    cur_byte;
	logic [7:0]    bit_mask;
	logic [7:0]    new_byte;
	logic          is_wr;
	logic          adv;
	out_word_t     res;

	// Modify stage
	always_comb begin
		cur_byte = fwd_sel_q ? fwd_q : mem_rd_q;
		bit_mask = 8'(1) << s1_cmd_q.bit_sel;
		is_wr    = (s1_cmd_q.op == OP_SET) || (s1_cmd_q.op == OP_CLR);
		new_byte = (s1_cmd_q.op == OP_SET) ? (cur_byte | bit_mask) : (cur_byte & ~bit_mask);
		res.read_data     = PIX_OFF;
		res.pixel_changed = 1'b0;
		unique case (s1_cmd_q.op)
			OP_SET, OP_CLR: res.pixel_changed = 1'b1;
			OP_RD_PAGE:     res.read_data = cur_byte;
			OP_RD_PIX:      res.read_data = ((cur_byte & bit_mask) != 8'd0) ? PIX_ON : PIX_OFF;
			default:        res.read_data = PIX_OFF;
		endcase
	end

	assign adv         = s1_valid_q && (!out_valid_q || out_ready);
	assign store_ready = !clr_busy_q;
	assign q_pop       = q_valid && store_ready && (!s1_valid_q || adv);
	assign out_valid   = out_valid_q;
	assign out_word    = out_word_q;

	// Memory: clearing sweep, then byte writes; registered read with bypass capture
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			store_mem[clr_idx_q] <= 8'd0;
		end else if (adv && is_wr) begin
			store_mem[s1_addr_q] <= new_byte;
		end
		if (q_pop) begin
			mem_rd_q  <= store_mem[q_addr];
			fwd_q     <= new_byte;
			fwd_sel_q <= adv && is_wr && (q_addr == s1_addr_q);
			s1_cmd_q  <= q_cmd;
			s1_addr_q <= q_addr;
		end
		if (adv) begin
			out_word_q <= res;
		end
	end

	// Clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == AW'(DEPTH - 1)) clr_busy_q <= 1'b0;
		end
	end

	// Stage and result valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop)    s1_valid_q <= 1'b1;
			else if (adv) s1_valid_q <= 1'b0;
			if (adv)            out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/mono_page_framebuffer_blit.sv =====
// Top level of the one-bit page-mode framebuffer with pixel blit and reads.
// One word is accepted per cycle, while the queue has room and no clearing pass
// runs, into a four-entry command queue; the back end does one read-modify-write
// of a page byte per cycle (one memory read port and one write port, read data
// registered, same-byte back-to-back writes bypassed), so sustained rate is one
// word per cycle while the output side is not held off. A result passes through
// the queue, the stage-one registers and the result register. After reset a
// clearing pass writes every byte of the store to zero, one byte per cycle;
// in_ready stays low during it while panel height writes are still taken.
module mono_page_framebuffer_blit #(
	parameter int DISPLAY_WIDTH = 128,
	parameter int MAX_ROWS      = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  mpfb_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output mpfb_pkg::out_word_t out_word
);
	import mpfb_pkg::*;

	localparam int DEPTH = DISPLAY_WIDTH * (MAX_ROWS / 8);
	localparam int AW    = $clog2(DEPTH);
	localparam int QW    = $bits(cmd_t) + AW;

	logic          q_push;
	logic          q_ready;
	cmd_t          f_cmd;
	logic [AW-1:0] f_addr;
	logic          q_valid;
	logic          q_pop;
	logic [QW-1:0] q_head;
	cmd_t          b_cmd;
	logic [AW-1:0] b_addr;
	logic          store_ready;

	assign b_cmd  = q_head[QW-1:AW];
	assign b_addr = q_head[AW-1:0];

	mpfb_front #(
		.DISPLAY_WIDTH(DISPLAY_WIDTH),
		.MAX_ROWS     (MAX_ROWS),
		.AW           (AW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_word    (in_word),
		.store_ready(store_ready),
		.q_ready    (q_ready),
		.q_push     (q_push),
		.q_cmd      (f_cmd),
		.q_addr     (f_addr)
	);

	mpfb_queue #(
		.DW(QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({f_cmd, f_addr}),
		.push_ready(q_ready),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_data  (q_head)
	);

	mpfb_back #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_cmd      (b_cmd),
		.q_addr     (b_addr),
		.q_pop      (q_pop),
		.store_ready(store_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_word   (out_word)
	);

endmodule

// ===== tb/mono_page_framebuffer_blit_tb.sv =====
// Self-checking testbench for the page-mode framebuffer blit block.
`timescale 1ns / 1ps

module mono_page_framebuffer_blit_tb;
	import mpfb_pkg::*;

	localparam int DISP_W         = 128;
	localparam int ROWS_MAX       = 64;
	localparam int STORE_BYTES    = DISP_W * ROWS_MAX / 8;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int TAIL_CYCLES    = 32;
	localparam int HOLD_AT        = 400;
	localparam int HOLD_CYCLES    = 400;

	// Request code the block ignores
	localparam logic [1:0] REQ_NONE = 2'd3;

	typedef enum logic [1:0] {
		ST_ITEM,
		ST_PANEL,
		ST_DRAIN
	} step_kind_t;

	// One entry of the send list: a word, a panel height write, or a pause
	typedef struct packed {
		step_kind_t kind;
		in_word_t   word;
		logic       panel;
	} req_step_t;

	// Expected result word, stamped with the time its request was taken
	typedef struct packed {
		out_word_t       word;
		longint unsigned stamp;
	} result_expect_t;

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      cfg_we    = 1'b0;
	logic      cfg_wdata = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_word_t  in_word   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_word;

	req_step_t      req_steps_q[$];
	result_expect_t pending_results_q[$];

	// Predictor state: pixel store and panel height
	logic [7:0]  panel_img [0:STORE_BYTES-1];
	logic        panel_short;

	int unsigned mismatches = 0;
	int unsigned results_seen = 0;
	int unsigned idle_cycles = 0;
	int unsigned tx_gap, tx_calm;
	int unsigned rx_stall, rx_calm, rx_hold;
	bit          hold_done;

	mono_page_framebuffer_blit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0t] ERROR %s", $time, msg);
	endtask

	// Gap length: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 20);
		return $urandom_range(21, 60);
	endfunction

	// Applies one request to the pixel store and returns its result word
	function automatic out_word_t predict_result(in_word_t w);
		out_word_t r;
		int        px, py, pg, rows, addr, b;
		logic      do_store, turn_on;
		r        = '0;
		px       = int'(w.pos_x);
		py       = int'(w.pos_y);
		pg       = int'(w.page_index);
		rows     = panel_short ? ROWS_MAX / 2 : ROWS_MAX;
		addr     = (py / 8) * DISP_W + px;
		b        = py % 8;
		do_store = 1'b0;
		turn_on  = 1'b0;
		case (w.req_type)
			REQ_BLIT: begin
				if (px < DISP_W && py < rows) begin
					case (w.blit_mode)
						MODE_OPAQUE: begin
							do_store = 1'b1;
							turn_on  = (w.src_value != PIX_OFF);
						end
						MODE_BLACK_CLR: begin
							if (w.src_value != PIX_OFF) begin
								do_store = 1'b1;
								turn_on  = 1'b1;
							end
						end
						MODE_WHITE_CLR: begin
							do_store = (w.src_value == PIX_OFF);
						end
						default: begin
							// only full black and full white are drawn
							do_store = (w.src_value == PIX_OFF) || (w.src_value == PIX_ON);
							turn_on  = (w.src_value == PIX_ON);
						end
					endcase
					if (do_store) begin
						panel_img[addr][b] = turn_on;
						r.pixel_changed    = 1'b1;
					end
				end
			end
			REQ_PAGE_RD: begin
				if (px < DISP_W && pg < rows / 8)
					r.read_data = panel_img[pg * DISP_W + px];
			end
			REQ_PIXEL_RD: begin
				if (px < DISP_W && py < rows)
					r.read_data = panel_img[addr][b] ? PIX_ON : PIX_OFF;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic in_word_t mk_word(logic [1:0] req, int x, int y, int pg, int src,
			logic [1:0] mode);
		in_word_t w;
		w.req_type   = req;
		w.pos_x      = 7'(x);
		w.pos_y      = 6'(y);
		w.page_index = 3'(pg);
		w.src_value  = 8'(src);
		w.blit_mode  = mode;
		return w;
	endfunction

	// Random request, half of them aimed at a small hot area so reads see writes
	function automatic in_word_t rand_word(int hot_x, int hot_y);
		in_word_t w;
		int       r;
		r = $urandom_range(0, 99);
		w.req_type   = (r < 50) ? REQ_BLIT : (r < 70) ? REQ_PAGE_RD :
			(r < 95) ? REQ_PIXEL_RD : REQ_NONE;
		w.page_index = 3'($urandom_range(0, 7));
		w.blit_mode  = 2'($urandom_range(0, 3));
		r = $urandom_range(0, 99);
		w.src_value  = (r < 25) ? PIX_OFF : (r < 50) ? PIX_ON : 8'($urandom_range(0, 255));
		if ($urandom_range(0, 1) == 0) begin
			w.pos_x = 7'(hot_x + $urandom_range(0, 3));
			w.pos_y = 6'(hot_y + $urandom_range(0, 15));
			w.page_index = 3'(int'(w.pos_y) / 8);
		end else begin
			w.pos_x = 7'($urandom_range(0, 127));
			w.pos_y = 6'($urandom_range(0, 63));
		end
		return w;
	endfunction

	function automatic void add_item(in_word_t w);
		req_step_t st;
		st.kind  = ST_ITEM;
		st.word  = w;
		st.panel = 1'b0;
		req_steps_q.push_back(st);
	endfunction

	function automatic void add_step(step_kind_t kind, logic panel);
		req_step_t st;
		st.kind  = kind;
		st.word  = '0;
		st.panel = panel;
		req_steps_q.push_back(st);
	endfunction

	// Driver: takes entries from the send list, predicts each accepted word
	always @(posedge clk or negedge arst_n) begin : drive_proc
		req_step_t      st;
		result_expect_t ex;
		logic           nxt_valid;
		in_word_t       nxt_word;
		logic           nxt_we;
		logic           nxt_wdata;
		if (!arst_n) begin
			in_valid    <= 1'b0;
			in_word     <= '0;
			cfg_we      <= 1'b0;
			cfg_wdata   <= 1'b0;
			tx_gap      = 0;
			tx_calm     = 0;
			panel_short = 1'b0;
			foreach (panel_img[i])
				panel_img[i] = 8'h00;
		end else begin
			if (in_valid && in_ready) begin
				ex.word  = predict_result(in_word);
				ex.stamp = $time;
				pending_results_q.push_back(ex);
			end
			nxt_valid = in_valid && !in_ready;
			nxt_word  = in_word;
			nxt_we    = 1'b0;
			nxt_wdata = cfg_wdata;
			if (!nxt_valid) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (req_steps_q.size() != 0) begin
					st = req_steps_q[0];
					case (st.kind)
						ST_ITEM: begin
							st        = req_steps_q.pop_front();
							nxt_valid = 1'b1;
							nxt_word  = st.word;
							if (tx_calm > 0) begin
								tx_calm--;
								tx_gap = 0;
							end else begin
								tx_gap = pick_gap();
								if ($urandom_range(0, 99) == 0)
									tx_calm = $urandom_range(30, 120);
							end
						end
						ST_PANEL: begin
							// height changes only with nothing in flight
							if (pending_results_q.size() == 0) begin
								st          = req_steps_q.pop_front();
								nxt_we      = 1'b1;
								nxt_wdata   = st.panel;
								panel_short = st.panel;
							end
						end
						default: begin
							if (pending_results_q.size() == 0)
								st = req_steps_q.pop_front();
						end
					endcase
				end
			end
			in_valid  <= nxt_valid;
			in_word   <= nxt_word;
			cfg_we    <= nxt_we;
			cfg_wdata <= nxt_wdata;
		end
	end

	// Monitor: checks each result word and paces out_ready
	always @(posedge clk or negedge arst_n) begin : monitor_proc
		result_expect_t ex;
		logic           nxt_ready;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_stall  = 0;
			rx_calm   = 0;
			rx_hold   = 0;
			hold_done = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (pending_results_q.size() == 0 || pending_results_q[0].stamp >= $time) begin
					report_mismatch($sformatf("result with no request: data=%02h changed=%0b",
						out_word.read_data, out_word.pixel_changed));
				end else begin
					ex = pending_results_q.pop_front();
					if (out_word.read_data !== ex.word.read_data)
						report_mismatch($sformatf("read_data %02h, predicted %02h",
							out_word.read_data, ex.word.read_data));
					if (out_word.pixel_changed !== ex.word.pixel_changed)
						report_mismatch($sformatf("pixel_changed %0b, predicted %0b",
							out_word.pixel_changed, ex.word.pixel_changed));
				end
			end
			// long hold-off once, while the sender keeps offering words
			if (rx_hold > 0) begin
				rx_hold--;
				nxt_ready = 1'b0;
			end else if (!hold_done && results_seen >= HOLD_AT && in_valid) begin
				hold_done = 1'b1;
				rx_hold   = HOLD_CYCLES;
				nxt_ready = 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				nxt_ready = 1'b0;
			end else begin
				nxt_ready = 1'b1;
				if (rx_calm > 0) begin
					rx_calm--;
				end else if ($urandom_range(0, 99) < 30) begin
					rx_stall = pick_gap();
				end else if ($urandom_range(0, 99) == 0) begin
					rx_calm = $urandom_range(30, 120);
				end
			end
			out_ready <= nxt_ready;
		end
	end

	// Watchdog: too long with no word moving on any port
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] ERROR watchdog expired", $time);
			$display("mono_page_framebuffer_blit: mismatch");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Stimulus
	initial begin
		int hot_x, hot_y;
		add_step(ST_PANEL, 1'b0);

		// directed: corners, every mode, transparency keeps
		add_item(mk_word(REQ_BLIT, 0, 0, 0, 255, MODE_OPAQUE));
		add_item(mk_word(REQ_PIXEL_RD, 0, 0, 0, 0, MODE_OPAQUE));
		add_item(mk_word(REQ_PAGE_RD, 0, 0, 0, 0, MODE_OPAQUE));
		add_item(mk_word(REQ_BLIT, 127, 63, 0, 1, MODE_OPAQUE));
		add_item(mk_word(REQ_PAGE_RD, 127, 0, 7, 0, MODE_OPAQUE));
		add_item(mk_word(REQ_PIXEL_RD, 127, 63, 7, 0, MODE_OPAQUE));
		add_item(mk_word(REQ_BLIT, 0, 0, 0, 0, MODE_BLACK_CLR));
		add_item(mk_word(REQ_BLIT, 5, 9, 1, 128, MODE_BLACK_CLR));
		add_item(mk_word(REQ_BLIT, 0, 0, 0, 7, MODE_WHITE_CLR));
		add_item(mk_word(REQ_BLIT, 0, 0, 0, 0, MODE_WHITE_CLR));
		add_item(mk_word(REQ_PIXEL_RD, 0, 0, 0, 0, MODE_OPAQUE));
		add_item(mk_word(REQ_BLIT, 64, 32, 4, 128, MODE_MID_CLR));
		add_item(mk_word(REQ_BLIT, 64, 32, 4, 255, MODE_MID_CLR));
		add_item(mk_word(REQ_BLIT, 127, 63, 7, 0, MODE_MID_CLR));
		add_item(mk_word(REQ_BLIT, 127, 63, 7, 0, MODE_OPAQUE));
		add_item(mk_word(REQ_NONE, 127, 63, 7, 255, MODE_MID_CLR));
		add_item(mk_word(REQ_PAGE_RD, 5, 0, 1, 0, MODE_OPAQUE));

		// short panel: upper rows and pages out of reach
		add_step(ST_PANEL, 1'b1);
		add_item(mk_word(REQ_BLIT, 3, 40, 5, 255, MODE_OPAQUE));
		add_item(mk_word(REQ_BLIT, 3, 31, 3, 255, MODE_OPAQUE));
		add_item(mk_word(REQ_PIXEL_RD, 64, 32, 4, 0, MODE_OPAQUE));
		add_item(mk_word(REQ_PAGE_RD, 64, 0, 4, 0, MODE_OPAQUE));
		add_item(mk_word(REQ_PAGE_RD, 3, 0, 3, 0, MODE_OPAQUE));

		// back to full height: hidden rows kept their bits
		add_step(ST_PANEL, 1'b0);
		add_item(mk_word(REQ_PIXEL_RD, 64, 32, 4, 0, MODE_OPAQUE));
		add_item(mk_word(REQ_PAGE_RD, 64, 0, 4, 0, MODE_OPAQUE));
		add_item(mk_word(REQ_BLIT, 64, 63, 7, 255, MODE_BLACK_CLR));
		add_item(mk_word(REQ_PAGE_RD, 64, 0, 7, 0, MODE_OPAQUE));

		// random phases, each with its own height and hot area
		for (int ph = 0; ph < 10; ph++) begin
			add_step(ST_PANEL, (ph < 2) ? 1'(ph) : 1'($urandom_range(0, 1)));
			hot_x = $urandom_range(0, 124);
			hot_y = $urandom_range(0, 48);
			for (int n = 0; n < 152; n++) begin
				add_item(rand_word(hot_x, hot_y));
				if ($urandom_range(0, 149) == 0)
					add_step(ST_DRAIN, 1'b0);
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (req_steps_q.size() != 0 || in_valid || pending_results_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results_q.size()));
		if (mismatches == 0)
			$display("mono_page_framebuffer_blit: match");
		else
			$display("mono_page_framebuffer_blit: mismatch");
		$finish;
	end

endmodule
